// File: rtl/core/kat_pkg.sv
// ---------------------------------------------------------------------------
// kat_pkg
// Shared types and constants of the keyed association table: record
// layout, cell control word, operation and status codes.
// ---------------------------------------------------------------------------
package kat_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned STAT_W  = 3;

  localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP2 = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_DELETE  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_ZERO_KEY = 3'd1;
  localparam logic [STAT_W-1:0] ST_ZERO_OBJ = 3'd2;
  localparam logic [STAT_W-1:0] ST_ABSENT   = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] value;
    logic [KEY_W-1:0] watcher;
  } entry_t;

  typedef struct packed {
    logic             cmp_en;
    logic             cmp_wat;
    logic [KEY_W-1:0] cmp_key;
    logic             upd_add;
    logic             upd_del;
  } cell_ctrl_t;

endpackage

// File: rtl/core/keyed_association_table_unit.sv
// ---------------------------------------------------------------------------
// keyed_association_table_unit
// Associative table of records kept newest first in a row of cells, with
// add, lookup by primary key, lookup by secondary key and delete.
// ---------------------------------------------------------------------------
//  channel | handshake              | words
//  --------+------------------------+----------------------------------------
//  in      | in_valid_i/in_ready_o  | func, owner_key, object_value, watcher_key
//  out     | out_valid_o/out_ready_i| success, found_value, status
//
//  every cell compares its record at the accept edge; the update state then applies
//  the shift or gap close and loads the output register
//  a new word is taken while the previous result waits in the output register
//  the update stalls while that register is still full and not taken
//  reset clears the valid bits of all cells; no clearing pass
module keyed_association_table_unit
  import kat_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [KEY_W-1:0]  owner_key_i,
  input  logic [KEY_W-1:0]  object_value_i,
  input  logic [KEY_W-1:0]  watcher_key_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              success_o,
  output logic [KEY_W-1:0]  found_value_o,
  output logic [STAT_W-1:0] status_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_UPD  = 1'b1;

  logic              state_q, state_d;
  logic              out_valid_q, out_valid_d;
  logic [FUNC_W-1:0] func_q;
  logic [KEY_W-1:0]  okey_q, obj_q, wkey_q;
  logic              success_q, success_d;
  logic [KEY_W-1:0]  found_q, found_d;
  logic [STAT_W-1:0] status_q, status_d;

  logic              in_fire, upd_go, do_add, do_del;
  logic              any_hit, full;
  cell_ctrl_t        ctrl;
  entry_t            ent [ENTRIES];
  entry_t            new_ent, tail_ent;
  logic [ENTRIES:0]  pre;
  logic [KEY_W-1:0]  found [ENTRIES+1];
  logic [KEY_W-1:0]  lkey;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign upd_go     = (state_q == S_UPD) && (!out_valid_q || out_ready_i);

  assign new_ent  = '{valid: 1'b1, key: okey_q, value: obj_q, watcher: wkey_q};
  assign tail_ent = '0;
  assign pre[0]   = 1'b0;
  assign found[0] = '0;
  assign any_hit  = pre[ENTRIES];
  assign full     = ent[ENTRIES-1].valid;
  assign lkey     = (func_q == FUNC_LOOKUP2) ? wkey_q : okey_q;

  always_comb begin
    do_add    = 1'b0;
    do_del    = 1'b0;
    success_d = 1'b0;
    found_d   = '0;
    status_d  = ST_OK;
    case (func_q)
      FUNC_ADD: begin
        if (okey_q == '0) begin
          status_d = ST_ZERO_KEY;
        end else if (obj_q == '0) begin
          status_d = ST_ZERO_OBJ;
        end else if (full && !any_hit) begin
          status_d = ST_FULL;
        end else begin
          success_d = 1'b1;
          do_add    = 1'b1;
        end
      end
      FUNC_LOOKUP, FUNC_LOOKUP2: begin
        if (lkey == '0) begin
          status_d = ST_ZERO_KEY;
        end else if (any_hit) begin
          success_d = 1'b1;
          found_d   = found[ENTRIES];
        end else begin
          status_d = ST_ABSENT;
        end
      end
      FUNC_DELETE: begin
        if (okey_q == '0) begin
          status_d = ST_ZERO_KEY;
        end else if (any_hit) begin
          success_d = 1'b1;
          do_del    = 1'b1;
        end else begin
          status_d = ST_ABSENT;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_comb begin
    ctrl.cmp_en  = in_fire;
    ctrl.cmp_wat = (func_i == FUNC_LOOKUP2);
    ctrl.cmp_key = (func_i == FUNC_LOOKUP2) ? watcher_key_i : owner_key_i;
    ctrl.upd_add = upd_go && do_add;
    ctrl.upd_del = upd_go && do_del;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kat_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .prev_i  ((i == 0) ? new_ent : ent[(i == 0) ? 0 : i-1]),
      .next_i  ((i == ENTRIES-1) ? tail_ent : ent[(i == ENTRIES-1) ? i : i+1]),
      .pre_i   (pre[i]),
      .pre_o   (pre[i+1]),
      .found_i (found[i]),
      .found_o (found[i+1]),
      .entry_o (ent[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (upd_go) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= func_i;
      okey_q <= owner_key_i;
      obj_q  <= object_value_i;
      wkey_q <= watcher_key_i;
    end
    if (upd_go) begin
      success_q <= success_d;
      found_q   <= found_d;
      status_q  <= status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign success_o     = success_q;
  assign found_value_o = found_q;
  assign status_o      = status_q;

endmodule

// File: rtl/core/kat_cell.sv
// ---------------------------------------------------------------------------
// kat_cell
// One slot of the table: holds a record, compares it against the search
// key and shifts towards the tail on insert or towards the head on delete.
// ---------------------------------------------------------------------------
module kat_cell
  import kat_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  entry_t           prev_i,
  input  entry_t           next_i,
  input  logic             pre_i,
  output logic             pre_o,
  input  logic [KEY_W-1:0] found_i,
  output logic [KEY_W-1:0] found_o,
  output entry_t           entry_o
);

  entry_t entry_q, entry_d;
  logic   hit_q, hit_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.upd_add && !pre_i) begin
      entry_d = prev_i;
    end else if (ctrl_i.upd_del && (pre_i || hit_q)) begin
      entry_d = next_i;
    end
  end

  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.cmp_en) begin
      hit_d = entry_q.valid &&
              ((ctrl_i.cmp_wat ? entry_q.watcher : entry_q.key) == ctrl_i.cmp_key);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      entry_q <= entry_d;
      hit_q   <= hit_d;
    end
  end

  // first hit in the chain drives the found value
  assign pre_o   = pre_i | hit_q;
  assign found_o = found_i | ((hit_q && !pre_i) ? entry_q.value : '0);
  assign entry_o = entry_q;

endmodule

// File: bench/tb_keyed_association_table_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_keyed_association_table_unit
// Self-checking bench for the keyed association table. A directed opening
// covers empty-table misses, zero keys and objects, replacement, newest-first
// secondary lookups and deletes. Random commands follow, grouped into filling,
// even, draining and probing runs over small key pools so that hits, full
// refusals and replacements on a full table are frequent. A shadow copy of the
// table predicts every reply at its accept edge, and the replies are checked
// in order. Both sides idle in random bursts, and the receiver holds off once
// for a long stretch so that the block backs up.
// ---------------------------------------------------------------------------
module tb_keyed_association_table_unit;
  import kat_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned N_RANDOM    = 1000;
  localparam int unsigned CALM_TAIL   = 150;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  okey;
    logic [KEY_W-1:0]  obj;
    logic [KEY_W-1:0]  wkey;
  } cmd_t;

  typedef struct {
    logic              ok;
    logic [KEY_W-1:0]  found;
    logic [STAT_W-1:0] status;
  } reply_t;

  typedef enum logic [1:0] {RUN_FILL, RUN_EVEN, RUN_DRAIN, RUN_PROBE} run_e;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [FUNC_W-1:0] func_i         = FUNC_ADD;
  logic [KEY_W-1:0]  owner_key_i    = '0;
  logic [KEY_W-1:0]  object_value_i = '0;
  logic [KEY_W-1:0]  watcher_key_i  = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic              success_o;
  logic [KEY_W-1:0]  found_value_o;
  logic [STAT_W-1:0] status_o;

  cmd_t   pending_cmds[$];
  reply_t awaited_replies[$];

  // shadow of the table, newest record in slot 0
  logic [KEY_W-1:0] shadow_key[ENTRIES];
  logic [KEY_W-1:0] shadow_val[ENTRIES];
  logic [KEY_W-1:0] shadow_wat[ENTRIES];
  int unsigned      shadow_used = 0;

  logic [KEY_W-1:0] owner_pool[20];
  logic [KEY_W-1:0] watcher_pool[5];

  int unsigned errors     = 0;
  int unsigned send_gap   = 0;
  int unsigned recv_hold  = 0;
  int unsigned replies_in = 0;
  int unsigned quiet      = 0;
  bit          squeezed   = 1'b0;

  keyed_association_table_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .owner_key_i    (owner_key_i),
    .object_value_i (object_value_i),
    .watcher_key_i  (watcher_key_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .success_o      (success_o),
    .found_value_o  (found_value_o),
    .status_o       (status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_bad(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
    errors++;
    $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
  endtask

  function automatic int slot_of(logic [KEY_W-1:0] key, bit by_watcher);
    for (int i = 0; i < int'(shadow_used); i++) begin
      if ((by_watcher ? shadow_wat[i] : shadow_key[i]) == key) return i;
    end
    return -1;
  endfunction

  function automatic void drop_slot(int pos);
    for (int i = pos; i + 1 < int'(shadow_used); i++) begin
      shadow_key[i] = shadow_key[i+1];
      shadow_val[i] = shadow_val[i+1];
      shadow_wat[i] = shadow_wat[i+1];
    end
    shadow_used--;
  endfunction

  function automatic reply_t apply_to_table(cmd_t c);
    reply_t r;
    int     pos;
    r.ok     = 1'b0;
    r.found  = '0;
    r.status = ST_OK;
    case (c.func)
      FUNC_ADD: begin
        if (c.okey == '0) r.status = ST_ZERO_KEY;
        else if (c.obj == '0) r.status = ST_ZERO_OBJ;
        else begin
          pos = slot_of(c.okey, 1'b0);
          if (pos >= 0) drop_slot(pos);
          if (shadow_used >= ENTRIES) r.status = ST_FULL;
          else begin
            for (int i = int'(shadow_used); i > 0; i--) begin
              shadow_key[i] = shadow_key[i-1];
              shadow_val[i] = shadow_val[i-1];
              shadow_wat[i] = shadow_wat[i-1];
            end
            shadow_key[0] = c.okey;
            shadow_val[0] = c.obj;
            shadow_wat[0] = c.wkey;
            shadow_used++;
            r.ok = 1'b1;
          end
        end
      end
      FUNC_LOOKUP, FUNC_LOOKUP2: begin
        if ((c.func == FUNC_LOOKUP ? c.okey : c.wkey) == '0) r.status = ST_ZERO_KEY;
        else begin
          pos = (c.func == FUNC_LOOKUP) ? slot_of(c.okey, 1'b0) : slot_of(c.wkey, 1'b1);
          if (pos >= 0) begin
            r.ok    = 1'b1;
            r.found = shadow_val[pos];
          end else r.status = ST_ABSENT;
        end
      end
      default: begin
        if (c.okey == '0) r.status = ST_ZERO_KEY;
        else begin
          pos = slot_of(c.okey, 1'b0);
          if (pos >= 0) begin
            drop_slot(pos);
            r.ok = 1'b1;
          end else r.status = ST_ABSENT;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void queue_cmd(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                                    logic [KEY_W-1:0] v, logic [KEY_W-1:0] w);
    cmd_t c;
    c.func = f;
    c.okey = k;
    c.obj  = v;
    c.wkey = w;
    pending_cmds.push_back(c);
  endfunction

  function automatic logic [KEY_W-1:0] pick_owner();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 12) return $urandom;
    return owner_pool[$urandom_range(0, 19)];
  endfunction

  function automatic logic [KEY_W-1:0] pick_watcher();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 25) return $urandom;
    return watcher_pool[$urandom_range(0, 4)];
  endfunction

  function automatic logic [KEY_W-1:0] pick_object();
    if ($urandom_range(0, 99) < 4) return '0;
    return $urandom;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t nxt;
    cmd_t seen;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        seen.func = func_i;
        seen.okey = owner_key_i;
        seen.obj  = object_value_i;
        seen.wkey = watcher_key_i;
        awaited_replies.push_back(apply_to_table(seen));
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap == 0 && pending_cmds.size() > CALM_TAIL &&
            (pending_cmds.size() / 100) % 2 == 0 && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 11);
        end
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          nxt = pending_cmds.pop_front();
          func_i         <= nxt.func;
          owner_key_i    <= nxt.okey;
          object_value_i <= nxt.obj;
          watcher_key_i  <= nxt.wkey;
          in_valid_i     <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        replies_in++;
        if (awaited_replies.size() == 0) begin
          report_bad("reply with nothing pending", found_value_o, '0);
        end else begin
          want = awaited_replies.pop_front();
          if (success_o !== want.ok)
            report_bad("success", KEY_W'(success_o), KEY_W'(want.ok));
          if (found_value_o !== want.found)
            report_bad("found_value", found_value_o, want.found);
          if (status_o !== want.status)
            report_bad("status", KEY_W'(status_o), KEY_W'(want.status));
        end
      end
      // one long hold-off so that the block backs up
      if (!squeezed && replies_in >= 200) begin
        squeezed  = 1'b1;
        recv_hold = 80;
      end
      if (recv_hold == 0 && pending_cmds.size() > CALM_TAIL &&
          (replies_in / 64) % 2 == 1 && $urandom_range(0, 5) == 0) begin
        recv_hold = $urandom_range(1, 11);
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned      made;
    int unsigned      run_len;
    int unsigned      r;
    run_e             run;
    logic [FUNC_W-1:0] f;

    for (int i = 0; i < 20; i++) begin
      do owner_pool[i] = $urandom; while (owner_pool[i] == '0);
    end
    watcher_pool[0] = '0;
    for (int i = 1; i < 5; i++) begin
      do watcher_pool[i] = $urandom; while (watcher_pool[i] == '0);
    end

    // empty table, zero keys and objects
    queue_cmd(FUNC_LOOKUP,  owner_pool[0], $urandom, $urandom);
    queue_cmd(FUNC_LOOKUP2, $urandom, $urandom, watcher_pool[1]);
    queue_cmd(FUNC_DELETE,  owner_pool[0], $urandom, $urandom);
    queue_cmd(FUNC_ADD,     '0, '0, $urandom);
    queue_cmd(FUNC_ADD,     owner_pool[0], '0, $urandom);
    queue_cmd(FUNC_LOOKUP,  '0, $urandom, $urandom);
    queue_cmd(FUNC_LOOKUP2, $urandom, $urandom, '0);
    queue_cmd(FUNC_DELETE,  '0, $urandom, $urandom);
    // extremes, newest-first secondary match, replacement
    queue_cmd(FUNC_ADD,     '1, '1, '0);
    queue_cmd(FUNC_ADD,     32'd1, 32'd1, '1);
    queue_cmd(FUNC_ADD,     32'd2, 32'h8000_0000, '1);
    queue_cmd(FUNC_LOOKUP,  '1, '0, '0);
    queue_cmd(FUNC_LOOKUP2, '0, '0, '1);
    queue_cmd(FUNC_ADD,     32'd1, 32'h1234_5678, 32'd5);
    queue_cmd(FUNC_LOOKUP2, '1, '1, '1);
    queue_cmd(FUNC_LOOKUP,  32'd1, '0, '0);
    queue_cmd(FUNC_DELETE,  32'd2, '1, '1);
    queue_cmd(FUNC_LOOKUP2, '0, '0, '1);
    queue_cmd(FUNC_LOOKUP2, '0, '0, 32'd5);
    queue_cmd(FUNC_DELETE,  '1, '0, '0);
    queue_cmd(FUNC_LOOKUP,  '1, '0, '0);
    queue_cmd(FUNC_DELETE,  32'd1, '0, '0);

    made = 0;
    while (made < N_RANDOM) begin
      run     = run_e'($urandom_range(0, 3));
      run_len = $urandom_range(10, 40);
      for (int n = 0; n < int'(run_len); n++) begin
        r = $urandom_range(0, 99);
        case (run)
          RUN_FILL:  f = r < 70 ? FUNC_ADD : r < 80 ? FUNC_LOOKUP :
                         r < 90 ? FUNC_LOOKUP2 : FUNC_DELETE;
          RUN_EVEN:  f = r < 25 ? FUNC_ADD : r < 50 ? FUNC_LOOKUP :
                         r < 75 ? FUNC_LOOKUP2 : FUNC_DELETE;
          RUN_DRAIN: f = r < 15 ? FUNC_ADD : r < 35 ? FUNC_LOOKUP :
                         r < 45 ? FUNC_LOOKUP2 : FUNC_DELETE;
          default:   f = r < 10 ? FUNC_ADD : r < 55 ? FUNC_LOOKUP :
                         r < 95 ? FUNC_LOOKUP2 : FUNC_DELETE;
        endcase
        queue_cmd(f, pick_owner(), pick_object(), pick_watcher());
        made++;
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (pending_cmds.size() != 0 || in_valid_i || awaited_replies.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/kat_pkg.sv
rtl/core/kat_cell.sv
rtl/core/keyed_association_table_unit.sv
bench/tb_keyed_association_table_unit.sv
